// ----- src/mwcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mwcs_pkg: shared types and constants for the masked weighted choice sampler
// Request and result structs, the internal work-request struct, action codes.
// ----------------------------------------------------------------------------
package mwcs_pkg;

  localparam int MAX_CHOICES = 16;
  localparam int WEIGHT_W    = 8;
  localparam int SUM_W       = 12;  // 16 * 255 fits in 12 bits
  localparam int CNT_W       = 5;   // popcount of 16 bits
  localparam int IDX_W       = 4;
  localparam int DRAW_W      = 32;
  localparam int TAG_W       = 8;
  localparam int PROD_W      = DRAW_W + SUM_W;

  localparam logic [IDX_W-1:0] FIRST_SWITCH = IDX_W'(4);
  localparam logic [IDX_W-1:0] FIRST_ITEM   = IDX_W'(10);

  typedef enum logic [1:0] {
    CLASS_MOVE   = 2'd0,
    CLASS_SWITCH = 2'd1,
    CLASS_ITEM   = 2'd2,
    CLASS_NONE   = 2'd3
  } action_class_t;

  typedef struct packed {
    logic                   kind;
    logic [MAX_CHOICES-1:0] legal_bits;
    logic [TAG_W-1:0]       item_id;
    logic [63:0]            weights_low;
    logic [63:0]            weights_high;
    logic [DRAW_W-1:0]      draw;
    logic [TAG_W-1:0]       sequence_in;
  } in_t;

  typedef struct packed {
    action_class_t    action_class;
    logic [TAG_W-1:0] payload;
    logic [IDX_W-1:0] chosen_index;
    logic [TAG_W-1:0] sequence_out;
  } out_t;

  // Classified request handed from front to back: inclusive prefix sums of
  // the effective weights (weights, or 1 per legal choice) and their total.
  typedef struct packed {
    logic [MAX_CHOICES-1:0][SUM_W-1:0] prefix;
    logic [SUM_W-1:0]                  span;
    logic                              none;
    logic [DRAW_W-1:0]                 draw;
    logic [TAG_W-1:0]                  item_id;
    logic [TAG_W-1:0]                  sequence_in;
  } work_t;

endpackage

// ----- src/mwcs_front.sv -----
// ----------------------------------------------------------------------------
// mwcs_front: request intake and classification
// Masks choices, builds weight and count prefix sums, picks the sampling mode.
// ----------------------------------------------------------------------------
module mwcs_front
  import mwcs_pkg::*;
#(
  parameter int NUM_CHOICES = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  in_t   in_data,
  output logic  q_push,
  input  logic  q_full,
  output work_t q_data
);

  logic [MAX_CHOICES-1:0] legal;
  logic [MAX_CHOICES-1:0][SUM_W-1:0] wlev [0:IDX_W];
  logic [MAX_CHOICES-1:0][CNT_W-1:0] clev [0:IDX_W];
  logic [SUM_W-1:0] total;
  logic             use_weights;
  work_t            work;
  logic             f_valid;
  work_t            f_data;
  logic             f_ok;

  // Parallel prefix (log-step) over sixteen lanes: four levels of adds.
  always_comb begin
    for (int i = 0; i < MAX_CHOICES; i++) begin
      legal[i] = in_data.legal_bits[i] && (i < NUM_CHOICES);
      if (i < 8) begin
        wlev[0][i] = legal[i] ? SUM_W'(in_data.weights_low[WEIGHT_W*i +: WEIGHT_W]) : '0;
      end else begin
        wlev[0][i] = legal[i] ? SUM_W'(in_data.weights_high[WEIGHT_W*(i-8) +: WEIGHT_W])
                              : '0;
      end
      clev[0][i] = CNT_W'(legal[i]);
    end
    for (int d = 0; d < IDX_W; d++) begin
      for (int i = 0; i < MAX_CHOICES; i++) begin
        if (i >= (1 << d)) begin
          wlev[d+1][i] = wlev[d][i] + wlev[d][i - (1 << d)];
          clev[d+1][i] = clev[d][i] + clev[d][i - (1 << d)];
        end else begin
          wlev[d+1][i] = wlev[d][i];
          clev[d+1][i] = clev[d][i];
        end
      end
    end
    total       = wlev[IDX_W][MAX_CHOICES-1];
    use_weights = in_data.kind && (total != '0);

    for (int i = 0; i < MAX_CHOICES; i++) begin
      work.prefix[i] = use_weights ? wlev[IDX_W][i] : SUM_W'(clev[IDX_W][i]);
    end
    work.span        = use_weights ? total : SUM_W'(clev[IDX_W][MAX_CHOICES-1]);
    work.none        = (clev[IDX_W][MAX_CHOICES-1] == '0);
    work.draw        = in_data.draw;
    work.item_id     = in_data.item_id;
    work.sequence_in = in_data.sequence_in;
  end

  assign f_ok   = !f_valid || !q_full;
  assign full   = !f_ok;
  assign q_push = f_valid && !q_full;
  assign q_data = f_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_ok) begin
      f_valid <= push;
    end
    if (push && f_ok) begin
      f_data <= work;
    end
  end

endmodule

// ----- src/mwcs_queue.sv -----
// ----------------------------------------------------------------------------
// mwcs_queue: small request queue between front and back
// Circular buffer of classified requests; head shown while not empty.
// ----------------------------------------------------------------------------
module mwcs_queue
  import mwcs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  work_t data_in,
  output logic  valid,
  input  logic  pop,
  output work_t data_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

endmodule

// ----- src/mwcs_back.sv -----
// ----------------------------------------------------------------------------
// mwcs_back: draw scaling and interval search
// Stage A scales the draw by the span; stage B finds the interval and maps it.
// ----------------------------------------------------------------------------
module mwcs_back
  import mwcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_pop,
  input  work_t q_data,
  output logic  empty,
  input  logic  pop,
  output out_t  out_data
);

  logic [PROD_W-1:0] product;
  logic              out_ok;
  logic              a_ok;

  logic                              a_valid;
  logic [SUM_W-1:0]                  a_k;
  logic [MAX_CHOICES-1:0][SUM_W-1:0] a_prefix;
  logic                              a_none;
  logic [TAG_W-1:0]                  a_item;
  logic [TAG_W-1:0]                  a_seq;

  logic             found;
  logic [IDX_W-1:0] idx;
  out_t             result;
  logic             o_valid;

  assign out_ok = !o_valid || pop;
  assign a_ok   = !a_valid || out_ok;
  assign q_pop  = q_valid && a_ok;
  assign empty  = !o_valid;

  // 32 x 12 multiply; k keeps the integer part of draw * span / 2^32.
  assign product = PROD_W'(q_data.draw) * PROD_W'(q_data.span);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ok) begin
      a_valid <= q_valid;
    end
    if (q_pop) begin
      a_k      <= product[DRAW_W +: SUM_W];
      a_prefix <= q_data.prefix;
      a_none   <= q_data.none;
      a_item   <= q_data.item_id;
      a_seq    <= q_data.sequence_in;
    end
  end

  // First choice whose inclusive prefix exceeds k; scanning down leaves the
  // lowest hit.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = MAX_CHOICES - 1; i >= 0; i--) begin
      if (a_k < a_prefix[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
    result.sequence_out = a_seq;
    if (a_none || !found) begin
      result.action_class = CLASS_NONE;
      result.payload      = '0;
      result.chosen_index = '0;
    end else if (idx < FIRST_SWITCH) begin
      result.action_class = CLASS_MOVE;
      result.payload      = TAG_W'(idx);
      result.chosen_index = idx;
    end else if (idx < FIRST_ITEM) begin
      result.action_class = CLASS_SWITCH;
      result.payload      = TAG_W'(idx - FIRST_SWITCH);
      result.chosen_index = idx;
    end else begin
      result.action_class = CLASS_ITEM;
      result.payload      = a_item;
      result.chosen_index = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_ok) begin
      o_valid <= a_valid;
    end
    if (out_ok && a_valid) begin
      out_data <= result;
    end
  end

endmodule

// ----- src/masked_weighted_choice_sampler.sv -----
// ----------------------------------------------------------------------------
// masked_weighted_choice_sampler: roulette-wheel choice over masked choices
// Front classifies each request, a short queue decouples it from the back.
// ----------------------------------------------------------------------------
// Path: front register, queue, back stage A, back output register.
// Throughput: one request per cycle while results are popped; the 32x12 draw multiply is one stage.
// Reset (synchronous rst): front register, queue and back stages empty,
// full low, empty high. No stored state outlives a request.
// ----------------------------------------------------------------------------
module masked_weighted_choice_sampler
  import mwcs_pkg::*;
#(
  parameter int NUM_CHOICES = 16,  // choices above this are ignored (2..16)
  parameter int QUEUE_DEPTH = 2    // front-to-back queue entries
) (
  input  logic clk,
  input  logic rst,
  // request side
  input  logic push,
  output logic full,
  input  in_t  in_data,
  // result side
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  // Front -> queue
  logic  fq_push;
  logic  fq_full;
  work_t fq_data;

  // Queue -> back
  logic  qb_valid;
  logic  qb_pop;
  work_t qb_data;

  // Front: masks out-of-range and illegal choices, builds the prefix sums
  // of either the weights (weighted mode with nonzero total) or of one per
  // legal choice (uniform mode or zero-total fallback), and flags the case
  // of no legal choice.
  mwcs_front #(
    .NUM_CHOICES (NUM_CHOICES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (fq_push),
    .q_full  (fq_full),
    .q_data  (fq_data)
  );

  // Queue lets the front keep taking requests while the result side stalls, until the queue fills.
  mwcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fq_push),
    .full     (fq_full),
    .data_in  (fq_data),
    .valid    (qb_valid),
    .pop      (qb_pop),
    .data_out (qb_data)
  );

  // Back: k = (draw * span) >> 32, then the first prefix above k picks the
  // choice, which is mapped to move / switch / item (none if no choice hits).
  // The output register is the result queue head.
  mwcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_pop    (qb_pop),
    .q_data   (qb_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ----- src/mwcs_checker.sv -----
// ----------------------------------------------------------------------------
// mwcs_checker: port-level checks for the sampler
// Reset state, result hold under stall, and choice-to-action consistency.
// ----------------------------------------------------------------------------
module mwcs_checker
  import mwcs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input in_t  in_data,
  input logic empty,
  input logic pop,
  input out_t out_data
);

  logic unused_in;
  assign unused_in = push ^ (^in_data);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result changed or vanished");

  a_move_map: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.action_class == CLASS_MOVE) |->
      (out_data.chosen_index < FIRST_SWITCH &&
       out_data.payload == TAG_W'(out_data.chosen_index)))
    else $error("move result inconsistent with chosen index");

  a_switch_map: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.action_class == CLASS_SWITCH) |->
      (out_data.chosen_index >= FIRST_SWITCH &&
       out_data.chosen_index < FIRST_ITEM &&
       out_data.payload == TAG_W'(out_data.chosen_index - FIRST_SWITCH)))
    else $error("switch result inconsistent with chosen index");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.action_class == CLASS_NONE) |->
      (out_data.chosen_index == '0 && out_data.payload == '0))
    else $error("none result carries nonzero index or payload");

endmodule

bind masked_weighted_choice_sampler mwcs_checker u_mwcs_checker (.*);
